// File: rtl/etmb_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler TRS matrix builder.
package etmb_pkg;

    localparam int ANG_W      = 21;
    localparam int XY_W       = 33;
    localparam int CORD_STEPS = 16;
    localparam int CORD_LAT   = CORD_STEPS + 1;
    localparam int ROT_LAT    = 2;
    localparam int Q_W        = 20;
    localparam int SCL_W      = 16;
    localparam int ENT_W      = 32;
    localparam int NUM_W      = 30;
    localparam int DEN_W      = 17;
    localparam int NUM_AXES   = 3;

    localparam logic signed [ANG_W-1:0] TWO_PI_Q16  = 21'sd411775;
    localparam logic signed [ANG_W-1:0] PI_Q16      = 21'sd205887;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 33'sd652032874;

    localparam logic [1:0] COL_LAST = 2'd3;

    localparam logic signed [ENT_W-1:0] ENT_MAX = 32'sh7fff_ffff;
    localparam logic signed [ENT_W-1:0] ENT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        NK_DIV,
        NK_ZERO,
        NK_POS_MAX,
        NK_NEG_MAX
    } nkind_t;

    typedef struct packed {
        nkind_t kind;
        logic   neg;
    } div_ctl_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] angle;
        logic                    neg;
    } fold_t;

    typedef struct packed {
        logic signed [SCL_W-1:0] sx;
        logic signed [SCL_W-1:0] sy;
        logic signed [SCL_W-1:0] sz;
        logic signed [ENT_W-1:0] mx;
        logic signed [ENT_W-1:0] my;
        logic signed [ENT_W-1:0] mz;
    } side_t;

    typedef struct packed {
        logic signed [Q_W-1:0] r00;
        logic signed [Q_W-1:0] r01;
        logic signed [Q_W-1:0] r02;
        logic signed [Q_W-1:0] r10;
        logic signed [Q_W-1:0] r11;
        logic signed [Q_W-1:0] r12;
        logic signed [Q_W-1:0] r20;
        logic signed [Q_W-1:0] r21;
        logic signed [Q_W-1:0] r22;
    } rot_t;

    typedef struct packed {
        logic [1:0]              column;
        logic signed [ENT_W-1:0] model0;
        logic signed [ENT_W-1:0] model1;
        logic signed [ENT_W-1:0] model2;
        logic                    sat;
        logic                    last;
    } col_side_t;

    function automatic logic signed [ANG_W-1:0] atan_q16(input int unsigned i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 21'sd51472;
            1:       v = 21'sd30385;
            2:       v = 21'sd16055;
            3:       v = 21'sd8150;
            4:       v = 21'sd4091;
            5:       v = 21'sd2047;
            6:       v = 21'sd1024;
            7:       v = 21'sd512;
            8:       v = 21'sd256;
            9:       v = 21'sd128;
            10:      v = 21'sd64;
            11:      v = 21'sd32;
            12:      v = 21'sd16;
            13:      v = 21'sd8;
            14:      v = 21'sd4;
            15:      v = 21'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // widen Q3.12 to Q16 and fold into [-pi/2, pi/2]
    function automatic fold_t fold_angle(input logic signed [15:0] ang);
        fold_t f;
        logic signed [ANG_W-1:0] a;
        a = {ang[15], ang, 4'b0000};
        if (a > PI_Q16) begin
            a = a - TWO_PI_Q16;
        end
        if (a < -PI_Q16) begin
            a = a + TWO_PI_Q16;
        end
        f.neg = 1'b0;
        if (a > HALF_PI_Q16) begin
            a = a - PI_Q16;
            f.neg = 1'b1;
        end else if (a < -HALF_PI_Q16) begin
            a = a + PI_Q16;
            f.neg = 1'b1;
        end
        f.angle = a;
        return f;
    endfunction

    function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] p;
        p = (2*Q_W)'(a) * (2*Q_W)'(b) + (2*Q_W)'(32768);
        return p[16+Q_W-1:16];
    endfunction

    function automatic logic signed [ENT_W-1:0] clip_ent(input logic signed [39:0] v);
        logic signed [ENT_W-1:0] r;
        if (v > 40'(ENT_MAX)) begin
            r = ENT_MAX;
        end else if (v < 40'(ENT_MIN)) begin
            r = ENT_MIN;
        end else begin
            r = v[ENT_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/etmb_cordic_lane.sv
// One sine/cosine lane: pipelined 16-step rotation-mode CORDIC plus output rounding.
module etmb_cordic_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [etmb_pkg::ANG_W-1:0] in_angle,
    input  logic                             in_neg,
    output logic                             out_valid,
    output logic signed [etmb_pkg::Q_W-1:0]   out_sin,
    output logic signed [etmb_pkg::Q_W-1:0]   out_cos
);
    import etmb_pkg::*;

    logic signed [XY_W-1:0]  x_reg [CORD_STEPS];
    logic signed [XY_W-1:0]  y_reg [CORD_STEPS];
    logic signed [ANG_W-1:0] a_reg [CORD_STEPS];
    logic                    n_reg [CORD_STEPS];
    logic                    v_reg [CORD_STEPS];

    logic signed [Q_W-1:0] sin_reg, cos_reg;
    logic                  vo_reg;
    logic signed [XY_W-1:0] xf, yf, xr, yr;

    for (genvar i = 0; i < CORD_STEPS; i++) begin : g_step
        logic signed [XY_W-1:0]  xp, yp, x_next, y_next;
        logic signed [ANG_W-1:0] ap, a_next;
        logic                    np, vp;

        if (i == 0) begin : g_first
            assign xp = CORDIC_GAIN;
            assign yp = '0;
            assign ap = in_angle;
            assign np = in_neg;
            assign vp = in_valid;
        end else begin : g_rest
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign ap = a_reg[i-1];
            assign np = n_reg[i-1];
            assign vp = v_reg[i-1];
        end

        always_comb begin
            if (ap >= 0) begin
                x_next = xp - (yp >>> i);
                y_next = yp + (xp >>> i);
                a_next = ap - atan_q16(i);
            end else begin
                x_next = xp + (yp >>> i);
                y_next = yp - (xp >>> i);
                a_next = ap + atan_q16(i);
            end
        end

        always_ff @(posedge clk) begin
            if (!rst_n) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= vp;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                a_reg[i] <= a_next;
                n_reg[i] <= np;
            end
        end
    end

    always_comb begin
        xf = n_reg[CORD_STEPS-1] ? -x_reg[CORD_STEPS-1] : x_reg[CORD_STEPS-1];
        yf = n_reg[CORD_STEPS-1] ? -y_reg[CORD_STEPS-1] : y_reg[CORD_STEPS-1];
        xr = xf + XY_W'(8192);
        yr = yf + XY_W'(8192);
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[CORD_STEPS-1];
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            cos_reg <= Q_W'(xr >>> 14);
            sin_reg <= Q_W'(yr >>> 14);
        end
    end

    assign out_valid = vo_reg;
    assign out_sin   = sin_reg;
    assign out_cos   = cos_reg;

endmodule

// File: rtl/etmb_rot.sv
// Y-X-Z rotation matrix from three sine/cosine pairs, two product stages.
module etmb_rot (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [etmb_pkg::Q_W-1:0] s1,
    input  logic signed [etmb_pkg::Q_W-1:0] c1,
    input  logic signed [etmb_pkg::Q_W-1:0] s2,
    input  logic signed [etmb_pkg::Q_W-1:0] c2,
    input  logic signed [etmb_pkg::Q_W-1:0] s3,
    input  logic signed [etmb_pkg::Q_W-1:0] c3,
    output logic                           out_valid,
    output etmb_pkg::rot_t                 out_rot
);
    import etmb_pkg::*;

    logic                  p1_valid_reg, p2_valid_reg;
    logic signed [Q_W-1:0] s1s2_reg, c1s2_reg, c1c3_reg, s1c3_reg, c2s3_reg;
    logic signed [Q_W-1:0] c1s3_reg, s1s3_reg, c2c3_reg, c2s1_reg, c1c2_reg;
    logic signed [Q_W-1:0] s2_reg, s3_reg, c3_reg;
    rot_t                  rot_reg, rot_next;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            s1s2_reg <= mulq(s1, s2);
            c1s2_reg <= mulq(c1, s2);
            c1c3_reg <= mulq(c1, c3);
            s1c3_reg <= mulq(c3, s1);
            c2s3_reg <= mulq(c2, s3);
            c1s3_reg <= mulq(c1, s3);
            s1s3_reg <= mulq(s1, s3);
            c2c3_reg <= mulq(c2, c3);
            c2s1_reg <= mulq(c2, s1);
            c1c2_reg <= mulq(c1, c2);
            s2_reg   <= s2;
            s3_reg   <= s3;
            c3_reg   <= c3;
            rot_reg  <= rot_next;
        end
    end

    always_comb begin
        rot_next.r00 = c1c3_reg + mulq(s1s2_reg, s3_reg);
        rot_next.r01 = c2s3_reg;
        rot_next.r02 = mulq(c1s2_reg, s3_reg) - s1c3_reg;
        rot_next.r10 = mulq(s1s2_reg, c3_reg) - c1s3_reg;
        rot_next.r11 = c2c3_reg;
        rot_next.r12 = mulq(c1c3_reg, s2_reg) + s1s3_reg;
        rot_next.r20 = c2s1_reg;
        rot_next.r21 = -s2_reg;
        rot_next.r22 = c1c2_reg;
    end

    assign out_valid = p2_valid_reg;
    assign out_rot   = rot_reg;

endmodule

// File: rtl/etmb_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per stage.
module etmb_div_lane (
    input  logic                          clk,
    input  logic                          en,
    input  logic [etmb_pkg::NUM_W-1:0]    in_num,
    input  logic [etmb_pkg::DEN_W-1:0]    in_den,
    input  etmb_pkg::div_ctl_t            in_ctl,
    output logic [etmb_pkg::NUM_W-1:0]    out_quot,
    output etmb_pkg::div_ctl_t            out_ctl
);
    import etmb_pkg::*;

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    div_ctl_t         ctl_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_stage
        logic [DEN_W-1:0] rp, dp, rem_next;
        logic [NUM_W-1:0] nqp;
        div_ctl_t         cp;
        logic [DEN_W:0]   trial;

        if (i == 0) begin : g_first
            assign rp  = '0;
            assign nqp = in_num;
            assign dp  = in_den;
            assign cp  = in_ctl;
        end else begin : g_rest
            assign rp  = rem_reg[i-1];
            assign nqp = nq_reg[i-1];
            assign dp  = den_reg[i-1];
            assign cp  = ctl_reg[i-1];
        end

        assign trial = {rp, nqp[NUM_W-1]};

        always_comb begin
            if (trial >= {1'b0, dp}) begin
                rem_next = DEN_W'(trial - {1'b0, dp});
            end else begin
                rem_next = trial[DEN_W-1:0];
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[i] <= rem_next;
                nq_reg[i]  <= {nqp[NUM_W-2:0], (trial >= {1'b0, dp})};
                den_reg[i] <= dp;
                ctl_reg[i] <= cp;
            end
        end
    end

    assign out_quot = nq_reg[NUM_W-1];
    assign out_ctl  = ctl_reg[NUM_W-1];

endmodule

// File: rtl/euler_trs_matrix_builder.sv
// Top level: Euler Y-X-Z TRS model and normal matrix builder, one column per beat.
// The four column beats of a pose share the column serialiser.
// A new pose is accepted only while the serialiser is idle or on its last column beat.
// The column divider lanes and CORDIC lanes are fully pipelined; the whole pipe holds on stall.
// Reset: synchronous active-low aresetn clears all valid flags; data registers are not reset.
module euler_trs_matrix_builder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, move_x, move_y, move_z
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // column, model_row0..2, normal_row0..2, zero pad
    output logic [199:0] m_tdata,
    // saturated
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);
    import etmb_pkg::*;

    localparam int SIDE_D = CORD_LAT + ROT_LAT;

    logic adv, ien;

    // input stage
    logic  s0_valid_reg;
    fold_t s0_fold_reg [NUM_AXES];
    side_t s0_side_reg;
    side_t side_reg [SIDE_D];

    // sine/cosine lanes: 0 = y, 1 = x, 2 = z
    logic [NUM_AXES-1:0]   cord_valid;
    logic signed [Q_W-1:0] sn [NUM_AXES];
    logic signed [Q_W-1:0] cs [NUM_AXES];

    logic rot_valid;
    rot_t rot;

    // serialiser
    logic       ser_valid_reg;
    logic [1:0] ser_cnt_reg;
    rot_t       ser_rot_reg;
    side_t      ser_side_reg;

    // column stage
    logic signed [SCL_W-1:0] col_sc;
    logic signed [Q_W-1:0]   col_r [NUM_AXES];
    col_side_t               col_side;
    logic [NUM_W-1:0]        col_num [NUM_AXES];
    logic [DEN_W-1:0]        col_den;
    div_ctl_t                col_ctl [NUM_AXES];

    logic             c0_valid_reg;
    col_side_t        c0_side_reg;
    logic [NUM_W-1:0] c0_num_reg [NUM_AXES];
    logic [DEN_W-1:0] c0_den_reg;
    div_ctl_t         c0_ctl_reg [NUM_AXES];

    logic      dvalid_reg [NUM_W];
    col_side_t dside_reg  [NUM_W];

    logic [NUM_W-1:0]        quot [NUM_AXES];
    div_ctl_t                qctl [NUM_AXES];
    logic signed [ENT_W-1:0] nrm  [NUM_AXES];

    logic         m_valid_reg;
    logic [199:0] m_data_reg;
    logic         m_user_reg, m_last_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign ien      = adv && (!ser_valid_reg || ser_cnt_reg == COL_LAST);
    assign s_tready = ien;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (ien) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ien) begin
            s0_fold_reg[0] <= fold_angle(s_tdata[31:16]);
            s0_fold_reg[1] <= fold_angle(s_tdata[15:0]);
            s0_fold_reg[2] <= fold_angle(s_tdata[47:32]);
            s0_side_reg.sx <= s_tdata[63:48];
            s0_side_reg.sy <= s_tdata[79:64];
            s0_side_reg.sz <= s_tdata[95:80];
            s0_side_reg.mx <= s_tdata[127:96];
            s0_side_reg.my <= s_tdata[159:128];
            s0_side_reg.mz <= s_tdata[191:160];
            side_reg[0]    <= s0_side_reg;
            for (int i = 1; i < SIDE_D; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    etmb_cordic_lane u_cord_y (
        .clk(aclk), .rst_n(aresetn), .en(ien), .in_valid(s0_valid_reg),
        .in_angle(s0_fold_reg[0].angle), .in_neg(s0_fold_reg[0].neg),
        .out_valid(cord_valid[0]), .out_sin(sn[0]), .out_cos(cs[0])
    );

    etmb_cordic_lane u_cord_x (
        .clk(aclk), .rst_n(aresetn), .en(ien), .in_valid(s0_valid_reg),
        .in_angle(s0_fold_reg[1].angle), .in_neg(s0_fold_reg[1].neg),
        .out_valid(cord_valid[1]), .out_sin(sn[1]), .out_cos(cs[1])
    );

    etmb_cordic_lane u_cord_z (
        .clk(aclk), .rst_n(aresetn), .en(ien), .in_valid(s0_valid_reg),
        .in_angle(s0_fold_reg[2].angle), .in_neg(s0_fold_reg[2].neg),
        .out_valid(cord_valid[2]), .out_sin(sn[2]), .out_cos(cs[2])
    );

    etmb_rot u_rot (
        .clk(aclk), .rst_n(aresetn), .en(ien), .in_valid(&cord_valid),
        .s1(sn[0]), .c1(cs[0]), .s2(sn[1]), .c2(cs[1]), .s3(sn[2]), .c3(cs[2]),
        .out_valid(rot_valid), .out_rot(rot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            ser_cnt_reg   <= '0;
        end else if (adv) begin
            if (ser_valid_reg && ser_cnt_reg != COL_LAST) begin
                ser_cnt_reg <= ser_cnt_reg + 2'd1;
            end else begin
                ser_valid_reg <= rot_valid;
                ser_cnt_reg   <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ien) begin
            ser_rot_reg  <= rot;
            ser_side_reg <= side_reg[SIDE_D-1];
        end
    end

    always_comb begin
        logic signed [39:0]      mprod;
        logic signed [ENT_W-1:0] ment [NUM_AXES];
        logic                    sat;
        logic [Q_W-1:0]          absr;
        logic [SCL_W:0]          abss;

        case (ser_cnt_reg)
            2'd0: begin
                col_sc   = ser_side_reg.sx;
                col_r[0] = ser_rot_reg.r00;
                col_r[1] = ser_rot_reg.r01;
                col_r[2] = ser_rot_reg.r02;
            end
            2'd1: begin
                col_sc   = ser_side_reg.sy;
                col_r[0] = ser_rot_reg.r10;
                col_r[1] = ser_rot_reg.r11;
                col_r[2] = ser_rot_reg.r12;
            end
            2'd2: begin
                col_sc   = ser_side_reg.sz;
                col_r[0] = ser_rot_reg.r20;
                col_r[1] = ser_rot_reg.r21;
                col_r[2] = ser_rot_reg.r22;
            end
            default: begin
                col_sc   = '0;
                col_r[0] = '0;
                col_r[1] = '0;
                col_r[2] = '0;
            end
        endcase

        abss    = col_sc[SCL_W-1] ? -{col_sc[SCL_W-1], col_sc} : {1'b0, col_sc};
        col_den = DEN_W'({abss, 1'b0});
        sat     = (col_sc == '0);

        for (int j = 0; j < NUM_AXES; j++) begin
            mprod   = 40'(col_sc) * 40'(col_r[j]) + 40'sd128;
            ment[j] = clip_ent(mprod >>> 8);
            if (mprod >>> 8 != 40'(ment[j])) begin
                sat = 1'b1;
            end
            absr = col_r[j][Q_W-1] ? Q_W'(-col_r[j]) : Q_W'(col_r[j]);
            col_num[j] = NUM_W'({absr, 9'b0}) + NUM_W'(abss);
            col_ctl[j].neg = (col_r[j] < 0) != (col_sc < 0);
            if (ser_cnt_reg == COL_LAST) begin
                col_ctl[j].kind = NK_ZERO;
            end else if (col_sc != '0) begin
                col_ctl[j].kind = NK_DIV;
            end else if (col_r[j] > 0) begin
                col_ctl[j].kind = NK_POS_MAX;
            end else if (col_r[j] < 0) begin
                col_ctl[j].kind = NK_NEG_MAX;
            end else begin
                col_ctl[j].kind = NK_ZERO;
            end
        end

        col_side.column = ser_cnt_reg;
        col_side.last   = (ser_cnt_reg == COL_LAST);
        if (ser_cnt_reg == COL_LAST) begin
            col_side.model0 = ser_side_reg.mx;
            col_side.model1 = ser_side_reg.my;
            col_side.model2 = ser_side_reg.mz;
            col_side.sat    = 1'b0;
        end else begin
            col_side.model0 = ment[0];
            col_side.model1 = ment[1];
            col_side.model2 = ment[2];
            col_side.sat    = sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_W; i++) begin
                dvalid_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            c0_valid_reg  <= ser_valid_reg;
            dvalid_reg[0] <= c0_valid_reg;
            for (int i = 1; i < NUM_W; i++) begin
                dvalid_reg[i] <= dvalid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c0_side_reg  <= col_side;
            c0_den_reg   <= col_den;
            c0_num_reg   <= col_num;
            c0_ctl_reg   <= col_ctl;
            dside_reg[0] <= c0_side_reg;
            for (int i = 1; i < NUM_W; i++) begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    for (genvar j = 0; j < NUM_AXES; j++) begin : g_div
        etmb_div_lane u_div (
            .clk(aclk), .en(adv),
            .in_num(c0_num_reg[j]), .in_den(c0_den_reg), .in_ctl(c0_ctl_reg[j]),
            .out_quot(quot[j]), .out_ctl(qctl[j])
        );

        always_comb begin
            case (qctl[j].kind)
                NK_DIV:     nrm[j] = qctl[j].neg ? -ENT_W'(quot[j]) : ENT_W'(quot[j]);
                NK_POS_MAX: nrm[j] = ENT_MAX;
                NK_NEG_MAX: nrm[j] = ENT_MIN;
                default:    nrm[j] = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dvalid_reg[NUM_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {6'b0, nrm[2], nrm[1], nrm[0],
                           dside_reg[NUM_W-1].model2, dside_reg[NUM_W-1].model1,
                           dside_reg[NUM_W-1].model0, dside_reg[NUM_W-1].column};
            m_user_reg <= dside_reg[NUM_W-1].sat;
            m_last_reg <= dside_reg[NUM_W-1].last;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;
    assign m_tlast    = m_last_reg;

endmodule

// File: rtl/etmb_checker.sv
// Port-level checker for the matrix builder, bound to the top level.
module etmb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata,
    input logic [0:0]   m_tuser,
    input logic         m_tlast
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid straight after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_last_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
        else $error("tlast does not match column index");

    a_trans_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == 1'b0 && m_tdata[193:98] == '0)
        else $error("translation column carries normals or saturation");

    a_col_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
            m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1)
        else $error("column beats out of order");

endmodule

bind euler_trs_matrix_builder etmb_checker u_etmb_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
